// ===== design/indexed_list_engine_defines.svh =====
// ============================================================================
// indexed_list_engine_defines.svh
// Assertion macros shared by the list engine checker.
// ============================================================================
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define ILE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ile_pkg.sv =====
// ============================================================================
// ile_pkg
// Types and codes shared by the indexed list engine modules.
// ============================================================================
package ile_pkg;

    localparam int POS_BITS       = 10;
    localparam int HANDLE_IO_BITS = 32;
    localparam int LIVE_BITS      = 11;

    typedef enum logic [2:0] {
        FN_APPEND = 3'd0,
        FN_INSERT = 3'd1,
        FN_ERASE  = 3'd2,
        FN_GET    = 3'd3,
        FN_SET    = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        K_NONE,
        K_WRITE,
        K_READ,
        K_INSERT,
        K_ERASE
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SHIFT,
        BK_FILL,
        BK_DONE
    } t_bk_state;

    typedef struct packed {
        t_cmd_kind              kind;
        t_status                status;
        logic [LIVE_BITS-1:0]   live_count;
    } t_cmd_ctl;

    typedef struct packed {
        logic [2:0]                func;
        logic [POS_BITS-1:0]       position;
        logic [HANDLE_IO_BITS-1:0] handle_in;
    } t_in_item;

    typedef struct packed {
        logic [HANDLE_IO_BITS-1:0] handle_out;
        logic [LIVE_BITS-1:0]      live_count;
        logic [1:0]                status;
    } t_out_item;

endpackage

// ===== design/ile_front.sv =====
// ============================================================================
// ile_front
// Accepts requests, checks bounds against the running count and issues
// memory commands to the back end.
// ============================================================================
module ile_front #(
    parameter int CAPACITY    = 1024,
    parameter int HANDLE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ile_pkg::t_in_item i_item,
    output logic              o_push,
    output ile_pkg::t_cmd_ctl o_ctl,
    output logic [$clog2(CAPACITY+1)+$clog2(CAPACITY)+HANDLE_BITS-1:0] o_data,
    input  logic              i_q_ready
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > ile_pkg::POS_BITS) ? CW : ile_pkg::POS_BITS;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [CMPW-1:0]        pos_x;
    logic [CMPW-1:0]        cnt_x;
    logic                   full;
    logic [AW-1:0]          addr;
    ile_pkg::t_cmd_kind     kind;
    ile_pkg::t_status       status;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    assign pos_x = CMPW'(i_item.position);
    assign cnt_x = CMPW'(r_count);
    assign full  = (r_count == CW'(CAPACITY));

    always_comb begin
        n_count = r_count;
        kind    = ile_pkg::K_NONE;
        status  = ile_pkg::ST_OK;
        addr    = AW'(i_item.position);
        unique case (ile_pkg::t_func'(i_item.func))
            ile_pkg::FN_APPEND: begin
                addr = AW'(r_count);
                if (full) begin
                    status = ile_pkg::ST_FULL;
                end else begin
                    kind    = ile_pkg::K_WRITE;
                    n_count = r_count + CW'(1);
                end
            end
            ile_pkg::FN_INSERT: begin
                if (pos_x > cnt_x) begin
                    status = ile_pkg::ST_BOUNDS;
                end else if (full) begin
                    status = ile_pkg::ST_FULL;
                end else begin
                    kind    = ile_pkg::K_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            ile_pkg::FN_ERASE: begin
                if (pos_x >= cnt_x) begin
                    status = ile_pkg::ST_BOUNDS;
                end else begin
                    kind    = ile_pkg::K_ERASE;
                    n_count = r_count - CW'(1);
                end
            end
            ile_pkg::FN_GET: begin
                if (pos_x >= cnt_x) begin
                    status = ile_pkg::ST_BOUNDS;
                end else begin
                    kind = ile_pkg::K_READ;
                end
            end
            ile_pkg::FN_SET: begin
                if (pos_x >= cnt_x) begin
                    status = ile_pkg::ST_BOUNDS;
                end else begin
                    kind = ile_pkg::K_WRITE;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ctl.kind       = kind;
    assign o_ctl.status     = status;
    assign o_ctl.live_count = ile_pkg::LIVE_BITS'(n_count);
    assign o_data           = {r_count, addr, HANDLE_BITS'(i_item.handle_in)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== design/ile_queue.sv =====
// ============================================================================
// ile_queue
// Two-entry command queue between front and back end.
// ============================================================================
module ile_queue #(
    parameter int DATA_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_ready,
    input  ile_pkg::t_cmd_ctl    i_ctl,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_valid,
    input  logic                 i_pop,
    output ile_pkg::t_cmd_ctl    o_ctl,
    output logic [DATA_BITS-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    ile_pkg::t_cmd_ctl    r_ctl  [DEPTH];
    logic [DATA_BITS-1:0] r_data [DEPTH];
    logic [PW-1:0]        r_wp;
    logic [PW-1:0]        r_rp;
    logic [NW-1:0]        r_fill;
    logic                 do_pop;

    assign o_ready = (r_fill != NW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_ctl   = r_ctl[r_rp];
    assign o_data  = r_data[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wp]  <= i_ctl;
            r_data[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + NW'(1);
            end else if (do_pop && !i_push) begin
                r_fill <= r_fill - NW'(1);
            end
        end
    end

endmodule

// ===== design/ile_back.sv =====
// ============================================================================
// ile_back
// Executes memory commands: single reads and writes, and the one-entry-per-
// cycle shifts of insert and erase. Holds the result register.
// ============================================================================
module ile_back #(
    parameter int CAPACITY    = 1024,
    parameter int HANDLE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  ile_pkg::t_cmd_ctl  i_ctl,
    input  logic [$clog2(CAPACITY+1)+$clog2(CAPACITY)+HANDLE_BITS-1:0] i_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ile_pkg::t_out_item o_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int DW = CW + AW + HANDLE_BITS;

    logic [HANDLE_BITS-1:0] r_mem [CAPACITY];
    logic [HANDLE_BITS-1:0] r_rdata;

    ile_pkg::t_bk_state     r_state,  n_state;
    ile_pkg::t_cmd_ctl      r_ctl,    n_ctl;
    logic [CW-1:0]          r_cnt,    n_cnt;
    logic [AW-1:0]          r_pos,    n_pos;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic [AW-1:0]          r_idx,    n_idx;
    logic [AW-1:0]          r_wr,     n_wr;
    ile_pkg::t_out_item     r_out,    n_out;
    logic                   r_out_valid, n_out_valid;

    logic [CW-1:0]          q_cnt;
    logic [AW-1:0]          q_pos;
    logic [HANDLE_BITS-1:0] q_handle;
    logic                   we, re;
    logic [AW-1:0]          wa, ra;
    logic [HANDLE_BITS-1:0] wd;
    logic                   more;
    logic [AW-1:0]          next_idx;

    assign q_cnt    = i_data[DW-1 -: CW];
    assign q_pos    = i_data[HANDLE_BITS +: AW];
    assign q_handle = i_data[HANDLE_BITS-1:0];

    always_comb begin
        n_state     = r_state;
        n_ctl       = r_ctl;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_handle    = r_handle;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_q_pop     = 1'b0;
        we          = 1'b0;
        wa          = r_wr;
        wd          = r_rdata;
        re          = 1'b0;
        ra          = r_idx;
        more        = 1'b0;
        next_idx    = r_idx;
        unique case (r_state)
            ile_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_ctl    = i_ctl;
                    n_cnt    = q_cnt;
                    n_pos    = q_pos;
                    n_handle = q_handle;
                    n_state  = ile_pkg::BK_DONE;
                    unique case (i_ctl.kind)
                        ile_pkg::K_READ: begin
                            re = 1'b1;
                            ra = q_pos;
                        end
                        ile_pkg::K_WRITE: begin
                            we = 1'b1;
                            wa = q_pos;
                            wd = q_handle;
                        end
                        ile_pkg::K_INSERT: begin
                            if (CW'(q_pos) == q_cnt) begin
                                we = 1'b1;
                                wa = q_pos;
                                wd = q_handle;
                            end else begin
                                re      = 1'b1;
                                ra      = AW'(q_cnt - CW'(1));
                                n_idx   = ra;
                                n_wr    = AW'(q_cnt);
                                n_state = ile_pkg::BK_SHIFT;
                            end
                        end
                        ile_pkg::K_ERASE: begin
                            if (CW'(q_pos) + CW'(1) != q_cnt) begin
                                re      = 1'b1;
                                ra      = q_pos + AW'(1);
                                n_idx   = ra;
                                n_wr    = q_pos;
                                n_state = ile_pkg::BK_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ile_pkg::BK_SHIFT: begin
                // move the entry read last cycle, fetch the next one
                we = 1'b1;
                wa = r_wr;
                wd = r_rdata;
                if (r_ctl.kind == ile_pkg::K_INSERT) begin
                    more     = (r_idx > r_pos);
                    next_idx = r_idx - AW'(1);
                end else begin
                    more     = (CW'(r_idx) + CW'(1) < r_cnt);
                    next_idx = r_idx + AW'(1);
                end
                if (more) begin
                    re    = 1'b1;
                    ra    = next_idx;
                    n_idx = next_idx;
                    n_wr  = r_idx;
                end else if (r_ctl.kind == ile_pkg::K_INSERT) begin
                    n_state = ile_pkg::BK_FILL;
                end else begin
                    n_state = ile_pkg::BK_DONE;
                end
            end
            ile_pkg::BK_FILL: begin
                we      = 1'b1;
                wa      = r_pos;
                wd      = r_handle;
                n_state = ile_pkg::BK_DONE;
            end
            ile_pkg::BK_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.handle_out = (r_ctl.kind == ile_pkg::K_READ)
                                     ? ile_pkg::HANDLE_IO_BITS'(r_rdata) : '0;
                    n_out.live_count = r_ctl.live_count;
                    n_out.status     = r_ctl.status;
                    n_out_valid      = 1'b1;
                    n_state          = ile_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ile_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= r_mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl    <= n_ctl;
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_handle <= n_handle;
        r_idx    <= n_idx;
        r_wr     <= n_wr;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ile_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== design/indexed_list_engine.sv =====
// ============================================================================
// indexed_list_engine
// Ordered list of element handles with append, insert, erase, get and set.
// ============================================================================
// The list lives in a single-port-write, single-port-read memory of CAPACITY
// entries. The front end checks every request against its own running count
// the cycle it arrives, so status and live_count are settled at acceptance;
// a two-entry queue hands the command to the back end, which does the memory
// work and holds the result in an output register. Append, get, set, an
// out-of-bounds request, a full list or an unknown code move no entries.
// Insert at position p with count c moves the entries from p up one place
// and then writes the new handle at p; erase moves the entries above p
// down one place. Insert at the end of the list and erase of the last
// entry move none. The shift moves one entry per cycle through the
// memory's read and write ports. The store needs no clearing pass after
// reset; only entries below the count are ever read. Requests are taken
// while the queue has room, also while a result waits to be taken.
// ============================================================================
module indexed_list_engine #(
    parameter int CAPACITY    = 1024,
    parameter int HANDLE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ile_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ile_pkg::t_out_item o_out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int DW = CW + AW + HANDLE_BITS;

    // command path: front -> queue -> back
    logic              push;
    logic              q_ready;
    ile_pkg::t_cmd_ctl f_ctl;
    logic [DW-1:0]     f_data;
    logic              q_valid;
    logic              q_pop;
    ile_pkg::t_cmd_ctl q_ctl;
    logic [DW-1:0]     q_data;

    // classify and count at transfer in
    ile_front #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (i_in_data),
        .o_push    (push),
        .o_ctl     (f_ctl),
        .o_data    (f_data),
        .i_q_ready (q_ready)
    );

    // decouple the two sides
    ile_queue #(
        .DATA_BITS (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_ctl   (f_ctl),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_ctl   (q_ctl),
        .o_data  (q_data)
    );

    // run memory work, hold the result
    ile_back #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_ctl       (q_ctl),
        .i_data      (q_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

// ===== design/ile_checker.sv =====
// ============================================================================
// ile_checker
// Port-level checks of the list engine, bound to the top level.
// ============================================================================
`include "indexed_list_engine_defines.svh"

module ile_checker #(
    parameter int CAPACITY = 1024
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ile_pkg::t_out_item o_out_data
);

    // hold a stalled result
    `ILE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")

    // full status only at capacity
    `ILE_ASSERT_SAME(a_full_count, i_clk, i_rst_n, o_out_valid && (o_out_data.status == ile_pkg::ST_FULL), o_out_data.live_count == ile_pkg::LIVE_BITS'(CAPACITY), "full status below capacity")

    // failed requests return no handle
    `ILE_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ile_pkg::ST_OK), o_out_data.handle_out == '0, "handle returned on failure")

    // no result straight out of reset
    `ILE_ASSERT_SAME(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid, "result present after reset")

endmodule

bind indexed_list_engine ile_checker #(
    .CAPACITY (CAPACITY)
) u_ile_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
